// File: rtl/core/cmse_pkg.sv
// Package: cube state types, face cycle tables, opcodes and turn/inverse functions.
package cmse_pkg;

    localparam int unsigned NUM_CORNERS = 8;
    localparam int unsigned NUM_EDGES   = 12;
    localparam int unsigned NUM_FACES   = 6;
    localparam int unsigned NUM_TWISTS  = 3;
    localparam int unsigned NUM_MOVES   = NUM_FACES * NUM_TWISTS;
    localparam int unsigned CODE_W      = 5;

    // Stream payload layout.
    localparam int unsigned OPCODE_W     = 2;
    localparam int unsigned MOVE_W       = 5;
    localparam int unsigned CORNER_W     = NUM_CORNERS * CODE_W;
    localparam int unsigned EDGE_W       = NUM_EDGES * CODE_W;
    localparam int unsigned IN_BITS      = OPCODE_W + MOVE_W + CORNER_W + EDGE_W;
    localparam int unsigned IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_BITS     = CORNER_W + EDGE_W;
    localparam int unsigned OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int unsigned IN_MOVE_LSB  = OPCODE_W;
    localparam int unsigned IN_CORN_LSB  = IN_MOVE_LSB + MOVE_W;
    localparam int unsigned IN_EDGE_LSB  = IN_CORN_LSB + CORNER_W;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [MOVE_W-1:0]   t_move;
    typedef logic [NUM_CORNERS-1:0][CODE_W-1:0] t_corners;
    typedef logic [NUM_EDGES-1:0][CODE_W-1:0]   t_edges;

    localparam t_opcode OP_MOVE   = 2'd0;
    localparam t_opcode OP_SOLVE  = 2'd1;
    localparam t_opcode OP_INVERT = 2'd2;
    localparam t_opcode OP_LOAD   = 2'd3;

    localparam t_move MOVE_LIMIT = t_move'(NUM_MOVES);

    // Four-member loops per face, faces U F R D B L.
    localparam logic [3:0] EDGE_CYCLE [NUM_FACES][4] = '{
        '{4'd0, 4'd2, 4'd3, 4'd1}, '{4'd3, 4'd7, 4'd11, 4'd6}, '{4'd2, 4'd5, 4'd10, 4'd7},
        '{4'd9, 4'd11, 4'd10, 4'd8}, '{4'd0, 4'd4, 4'd8, 4'd5}, '{4'd1, 4'd6, 4'd9, 4'd4}
    };
    localparam logic [2:0] CORNER_CYCLE [NUM_FACES][4] = '{
        '{3'd0, 3'd1, 3'd3, 3'd2}, '{3'd2, 3'd3, 3'd7, 3'd6}, '{3'd3, 3'd1, 3'd5, 3'd7},
        '{3'd4, 3'd6, 3'd7, 3'd5}, '{3'd1, 3'd0, 3'd4, 3'd5}, '{3'd0, 3'd2, 3'd6, 3'd4}
    };
    // Bit f set: quarter turns of face f flip edges (R, L) / twist corners (F, R, B, L).
    localparam logic [NUM_FACES-1:0] FACE_FLIPS  = 6'b100100;
    localparam logic [NUM_FACES-1:0] FACE_TWISTS = 6'b110110;

    function automatic t_corners f_solved_corners();
        t_corners c;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            c[i] = CODE_W'(i);
        end
        return c;
    endfunction

    function automatic t_edges f_solved_edges();
        t_edges e;
        for (int i = 0; i < NUM_EDGES; i++) begin
            e[i] = CODE_W'(2 * i);
        end
        return e;
    endfunction

    // Orientation field 3 reads as 0 once touched.
    function automatic logic [1:0] f_ori(logic [CODE_W-1:0] code);
        return (code[4:3] == 2'd3) ? 2'd0 : code[4:3];
    endfunction

    function automatic logic [CODE_W-1:0] f_ori_add(logic [CODE_W-1:0] code, logic up);
        logic [1:0] o;
        logic [1:0] n;
        o = f_ori(code);
        if (up) begin
            n = (o == 2'd2) ? 2'd0 : o + 2'd1;
        end else begin
            n = (o == 2'd0) ? 2'd2 : o - 2'd1;
        end
        return {n, code[2:0]};
    endfunction

    // Orientation negated mod 3.
    function automatic logic [1:0] f_ori_neg(logic [CODE_W-1:0] code);
        logic [1:0] o;
        o = f_ori(code);
        return (o == 2'd0) ? 2'd0 : 2'd3 - o;
    endfunction

    function automatic t_corners f_turn_corners(t_corners c, int unsigned face,
                                                int unsigned twist);
        t_corners   n;
        logic [2:0] p0, p1, p2, p3;
        logic       tw;
        n  = c;
        tw = FACE_TWISTS[face];
        if (twist == 1) begin
            p0 = CORNER_CYCLE[face][0];
            p1 = CORNER_CYCLE[face][1];
            p2 = CORNER_CYCLE[face][2];
            p3 = CORNER_CYCLE[face][3];
            n[p0] = c[p2];
            n[p2] = c[p0];
            n[p1] = c[p3];
            n[p3] = c[p1];
        end else begin
            if (twist == 0) begin
                if (tw) begin
                    p0 = CORNER_CYCLE[face][1];
                    p1 = CORNER_CYCLE[face][2];
                    p2 = CORNER_CYCLE[face][3];
                    p3 = CORNER_CYCLE[face][0];
                end else begin
                    p0 = CORNER_CYCLE[face][0];
                    p1 = CORNER_CYCLE[face][1];
                    p2 = CORNER_CYCLE[face][2];
                    p3 = CORNER_CYCLE[face][3];
                end
            end else begin
                if (tw) begin
                    p0 = CORNER_CYCLE[face][1];
                    p1 = CORNER_CYCLE[face][0];
                    p2 = CORNER_CYCLE[face][3];
                    p3 = CORNER_CYCLE[face][2];
                end else begin
                    p0 = CORNER_CYCLE[face][3];
                    p1 = CORNER_CYCLE[face][2];
                    p2 = CORNER_CYCLE[face][1];
                    p3 = CORNER_CYCLE[face][0];
                end
            end
            if (tw) begin
                n[p3] = f_ori_add(c[p2], 1'b1);
                n[p2] = f_ori_add(c[p1], 1'b0);
                n[p1] = f_ori_add(c[p0], 1'b1);
                n[p0] = f_ori_add(c[p3], 1'b0);
            end else begin
                n[p3] = c[p2];
                n[p2] = c[p1];
                n[p1] = c[p0];
                n[p0] = c[p3];
            end
        end
        return n;
    endfunction

    function automatic t_edges f_turn_edges(t_edges e, int unsigned face,
                                            int unsigned twist);
        t_edges            n;
        logic [3:0]        p0, p1, p2, p3;
        logic [CODE_W-1:0] fm;
        n  = e;
        fm = {4'd0, FACE_FLIPS[face]};
        if (twist == 1) begin
            p0 = EDGE_CYCLE[face][0];
            p1 = EDGE_CYCLE[face][1];
            p2 = EDGE_CYCLE[face][2];
            p3 = EDGE_CYCLE[face][3];
            n[p0] = e[p2];
            n[p2] = e[p0];
            n[p1] = e[p3];
            n[p3] = e[p1];
        end else begin
            if (twist == 0) begin
                p0 = EDGE_CYCLE[face][0];
                p1 = EDGE_CYCLE[face][1];
                p2 = EDGE_CYCLE[face][2];
                p3 = EDGE_CYCLE[face][3];
            end else begin
                p0 = EDGE_CYCLE[face][3];
                p1 = EDGE_CYCLE[face][2];
                p2 = EDGE_CYCLE[face][1];
                p3 = EDGE_CYCLE[face][0];
            end
            n[p3] = e[p2] ^ fm;
            n[p2] = e[p1] ^ fm;
            n[p1] = e[p0] ^ fm;
            n[p0] = e[p3] ^ fm;
        end
        return n;
    endfunction

    // Inverse permutation; on conflicting slots the highest source index wins,
    // slots nobody claims keep their old code.
    function automatic t_corners f_invert_corners(t_corners c);
        t_corners n;
        n = c;
        for (int j = 0; j < NUM_CORNERS; j++) begin
            for (int i = 0; i < NUM_CORNERS; i++) begin
                if (c[i][2:0] == 3'(j)) begin
                    n[j] = {f_ori_neg(c[i]), 3'(i)};
                end
            end
        end
        return n;
    endfunction

    function automatic t_edges f_invert_edges(t_edges e);
        t_edges n;
        n = e;
        for (int j = 0; j < NUM_EDGES; j++) begin
            for (int i = 0; i < NUM_EDGES; i++) begin
                if (e[i][4:1] == 4'(j)) begin
                    n[j] = {4'(i), e[i][0]};
                end
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/core/cube_move_state_engine_top.sv
// Top level: cube state register with move, solve, invert and load requests.
//
//  Channel   Dir  Ports               Payload (lowest bit first)
//  -------   ---  ------------------  ------------------------------------------------
//  request   in   s_axis_t{valid,...} opcode[1:0] move_index[6:2] corner_word_in[46:7]
//                                     edge_word_in[106:47], zero pad to 112
//  result    out  m_axis_t{valid,...} corner_word[39:0] edge_word[99:40], pad to 104
//
//  One request per cycle while s_axis_tready is high: the turn, solve, inverse or
//  load is worked out in one pass from the cube state register and the request,
//  and lands at the same edge in the state and in the result or skid register.
//  A two-entry output (result register plus skid register) lets a request be
//  taken while a result still waits; s_axis_tready drops only when both are full.
//  Synchronous active-low reset returns the cube to solved and empties the output.
module cube_move_state_engine_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // opcode, move_index, corner_word_in, edge_word_in, zero pad
    input  logic [cmse_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // corner_word, edge_word, zero pad
    output logic [cmse_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    cmse_pkg::t_opcode  req_opcode;
    cmse_pkg::t_move    req_move;
    cmse_pkg::t_corners req_corners;
    cmse_pkg::t_edges   req_edges;

    cmse_pkg::t_corners r_corners, n_corners;
    cmse_pkg::t_edges   r_edges,   n_edges;

    cmse_pkg::t_corners turn_corners [cmse_pkg::NUM_MOVES];
    cmse_pkg::t_edges   turn_edges   [cmse_pkg::NUM_MOVES];

    logic [cmse_pkg::OUT_BITS-1:0] n_result;
    logic [cmse_pkg::OUT_BITS-1:0] r_out_data;
    logic [cmse_pkg::OUT_BITS-1:0] r_skid_data;
    logic                          r_out_valid;
    logic                          r_skid_valid;
    logic                          req_accept;
    logic                          out_free;

    // Unpack the request.
    assign req_opcode  = s_axis_tdata[cmse_pkg::OPCODE_W-1:0];
    assign req_move    = s_axis_tdata[cmse_pkg::IN_CORN_LSB-1:cmse_pkg::IN_MOVE_LSB];
    assign req_corners = s_axis_tdata[cmse_pkg::IN_EDGE_LSB-1:cmse_pkg::IN_CORN_LSB];
    assign req_edges   = s_axis_tdata[cmse_pkg::IN_BITS-1:cmse_pkg::IN_EDGE_LSB];

    assign s_axis_tready = !r_skid_valid;
    assign req_accept    = s_axis_tvalid && s_axis_tready;
    assign out_free      = m_axis_tready || !r_out_valid;

    // All eighteen turns side by side, each a fixed rewiring of the state.
    always_comb begin
        for (int f = 0; f < cmse_pkg::NUM_FACES; f++) begin
            for (int t = 0; t < cmse_pkg::NUM_TWISTS; t++) begin
                turn_corners[f * cmse_pkg::NUM_TWISTS + t] =
                    cmse_pkg::f_turn_corners(r_corners, f, t);
                turn_edges[f * cmse_pkg::NUM_TWISTS + t] =
                    cmse_pkg::f_turn_edges(r_edges, f, t);
            end
        end
    end

    // Next cube state for the request at the port.
    always_comb begin
        n_corners = r_corners;
        n_edges   = r_edges;
        unique case (req_opcode)
            cmse_pkg::OP_MOVE: begin
                // Out-of-range move index: hold the state.
                if (req_move < cmse_pkg::MOVE_LIMIT) begin
                    n_corners = turn_corners[req_move];
                    n_edges   = turn_edges[req_move];
                end
            end
            cmse_pkg::OP_SOLVE: begin
                n_corners = cmse_pkg::f_solved_corners();
                n_edges   = cmse_pkg::f_solved_edges();
            end
            cmse_pkg::OP_INVERT: begin
                n_corners = cmse_pkg::f_invert_corners(r_corners);
                n_edges   = cmse_pkg::f_invert_edges(r_edges);
            end
            cmse_pkg::OP_LOAD: begin
                n_corners = req_corners;
                n_edges   = req_edges;
            end
            default: begin
                n_corners = r_corners;
                n_edges   = r_edges;
            end
        endcase
        n_result = {n_edges, n_corners};
    end

    // Cube state and output valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corners    <= cmse_pkg::f_solved_corners();
            r_edges      <= cmse_pkg::f_solved_edges();
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (req_accept) begin
                r_corners <= n_corners;
                r_edges   <= n_edges;
            end
            if (out_free) begin
                // Advance: skid entry first, else the fresh result.
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= req_accept;
                end
            end else if (req_accept) begin
                // Output stalled: park the fresh result in the skid entry.
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Result payload, no reset.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (req_accept) begin
                r_out_data <= n_result;
            end
        end else if (req_accept) begin
            r_skid_data <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(cmse_pkg::OUT_TDATA_W - cmse_pkg::OUT_BITS){1'b0}}, r_out_data};

endmodule

// File: test/cube_move_state_engine_top_tb.sv
// Testbench for cube_move_state_engine_top: scored face turns, solves, inverts and loads.
module cube_move_state_engine_top_tb;

    // Quiet cycles with no handshake on either side before the run is declared hung.
    localparam int STALL_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 8;

    // Four-member face loops, faces U F R D B L.
    localparam int EDGE_LOOP [6][4] = '{
        '{0, 2, 3, 1}, '{3, 7, 11, 6}, '{2, 5, 10, 7},
        '{9, 11, 10, 8}, '{0, 4, 8, 5}, '{1, 6, 9, 4}
    };
    localparam int CORNER_LOOP [6][4] = '{
        '{0, 1, 3, 2}, '{2, 3, 7, 6}, '{3, 1, 5, 7},
        '{4, 6, 7, 5}, '{1, 0, 4, 5}, '{0, 2, 6, 4}
    };
    // Quarter turns of R and L flip edges; of F, R, B and L twist corners.
    localparam bit FACE_FLIPS_EDGES   [6] = '{0, 0, 1, 0, 0, 1};
    localparam bit FACE_TWISTS_CORNER [6] = '{0, 1, 1, 0, 1, 1};

    typedef struct packed {
        logic [cmse_pkg::EDGE_W-1:0]   edges;
        logic [cmse_pkg::CORNER_W-1:0] corners;
    } t_cube_word;

    logic                             i_clk         = 1'b0;
    logic                             i_rst_n       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [cmse_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [cmse_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Predicted cube state, updated in request order.
    logic [cmse_pkg::CODE_W-1:0] cube_corners [cmse_pkg::NUM_CORNERS];
    logic [cmse_pkg::CODE_W-1:0] cube_edges   [cmse_pkg::NUM_EDGES];
    t_cube_word                  expected_states [$];

    int tx_idle_pct     = 0;
    int rx_idle_pct     = 0;
    int mismatches      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int op_count [4]    = '{0, 0, 0, 0};

    cube_move_state_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // opcode, move_index, corner_word_in, edge_word_in, zero pad
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // corner_word, edge_word, zero pad
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Cube state predictor
    // ------------------------------------------------------------------

    // Orientation field 3 counts as 0 once it is twisted or inverted.
    function automatic int unsigned code_orient(logic [cmse_pkg::CODE_W-1:0] code);
        return (code[4:3] == 2'd3) ? 0 : int'(code[4:3]);
    endfunction

    function automatic logic [cmse_pkg::CODE_W-1:0] corner_twist(
            logic [cmse_pkg::CODE_W-1:0] code, int unsigned delta);
        int unsigned o;
        o = (code_orient(code) + delta) % 3;
        return {2'(o), code[2:0]};
    endfunction

    function automatic void solve_cube();
        for (int i = 0; i < cmse_pkg::NUM_CORNERS; i++) begin
            cube_corners[i] = cmse_pkg::CODE_W'(i);
        end
        for (int i = 0; i < cmse_pkg::NUM_EDGES; i++) begin
            cube_edges[i] = cmse_pkg::CODE_W'(2 * i);
        end
    endfunction

    // Shift a -> b -> c -> d -> a, xoring the flip mask into every moved edge.
    function automatic void cycle_edges(int a, int b, int c, int d,
                                        logic [cmse_pkg::CODE_W-1:0] fm);
        logic [cmse_pkg::CODE_W-1:0] t;
        t = cube_edges[d];
        cube_edges[d] = cube_edges[c] ^ fm;
        cube_edges[c] = cube_edges[b] ^ fm;
        cube_edges[b] = cube_edges[a] ^ fm;
        cube_edges[a] = t ^ fm;
    endfunction

    // Same shift on corners; twisting ones alternate +1 and -1 mod 3.
    function automatic void cycle_corners(int a, int b, int c, int d, bit twist);
        logic [cmse_pkg::CODE_W-1:0] t;
        t = cube_corners[d];
        if (twist) begin
            cube_corners[d] = corner_twist(cube_corners[c], 1);
            cube_corners[c] = corner_twist(cube_corners[b], 2);
            cube_corners[b] = corner_twist(cube_corners[a], 1);
            cube_corners[a] = corner_twist(t, 2);
        end else begin
            cube_corners[d] = cube_corners[c];
            cube_corners[c] = cube_corners[b];
            cube_corners[b] = cube_corners[a];
            cube_corners[a] = t;
        end
    endfunction

    function automatic void turn_face(int unsigned move);
        int unsigned                 f;
        int unsigned                 tw;
        logic [cmse_pkg::CODE_W-1:0] fm;
        logic [cmse_pkg::CODE_W-1:0] t;
        if (move >= cmse_pkg::NUM_MOVES) return;
        f  = move / 3;
        tw = move % 3;
        fm = {4'd0, FACE_FLIPS_EDGES[f]};
        if (tw == 1) begin
            // Half turn: swap opposite members, no flips or twists.
            t = cube_edges[EDGE_LOOP[f][0]];
            cube_edges[EDGE_LOOP[f][0]] = cube_edges[EDGE_LOOP[f][2]];
            cube_edges[EDGE_LOOP[f][2]] = t;
            t = cube_edges[EDGE_LOOP[f][1]];
            cube_edges[EDGE_LOOP[f][1]] = cube_edges[EDGE_LOOP[f][3]];
            cube_edges[EDGE_LOOP[f][3]] = t;
            t = cube_corners[CORNER_LOOP[f][0]];
            cube_corners[CORNER_LOOP[f][0]] = cube_corners[CORNER_LOOP[f][2]];
            cube_corners[CORNER_LOOP[f][2]] = t;
            t = cube_corners[CORNER_LOOP[f][1]];
            cube_corners[CORNER_LOOP[f][1]] = cube_corners[CORNER_LOOP[f][3]];
            cube_corners[CORNER_LOOP[f][3]] = t;
        end else if (tw == 0) begin
            cycle_edges(EDGE_LOOP[f][0], EDGE_LOOP[f][1], EDGE_LOOP[f][2], EDGE_LOOP[f][3], fm);
            if (FACE_TWISTS_CORNER[f]) begin
                cycle_corners(CORNER_LOOP[f][1], CORNER_LOOP[f][2],
                              CORNER_LOOP[f][3], CORNER_LOOP[f][0], 1'b1);
            end else begin
                cycle_corners(CORNER_LOOP[f][0], CORNER_LOOP[f][1],
                              CORNER_LOOP[f][2], CORNER_LOOP[f][3], 1'b0);
            end
        end else begin
            cycle_edges(EDGE_LOOP[f][3], EDGE_LOOP[f][2], EDGE_LOOP[f][1], EDGE_LOOP[f][0], fm);
            if (FACE_TWISTS_CORNER[f]) begin
                cycle_corners(CORNER_LOOP[f][1], CORNER_LOOP[f][0],
                              CORNER_LOOP[f][3], CORNER_LOOP[f][2], 1'b1);
            end else begin
                cycle_corners(CORNER_LOOP[f][3], CORNER_LOOP[f][2],
                              CORNER_LOOP[f][1], CORNER_LOOP[f][0], 1'b0);
            end
        end
    endfunction

    // Codes are visited in index order, so the last writer of a slot wins;
    // edge slots past 11 are dropped and unclaimed slots keep their code.
    function automatic void invert_cube();
        logic [cmse_pkg::CODE_W-1:0] nc [cmse_pkg::NUM_CORNERS];
        logic [cmse_pkg::CODE_W-1:0] ne [cmse_pkg::NUM_EDGES];
        logic [cmse_pkg::CODE_W-1:0] v;
        int unsigned                 neg;
        nc = cube_corners;
        ne = cube_edges;
        for (int i = 0; i < cmse_pkg::NUM_CORNERS; i++) begin
            v   = cube_corners[i];
            neg = (3 - code_orient(v)) % 3;
            nc[v[2:0]] = {2'(neg), 3'(i)};
        end
        for (int i = 0; i < cmse_pkg::NUM_EDGES; i++) begin
            v = cube_edges[i];
            if (v[4:1] < cmse_pkg::NUM_EDGES) ne[v[4:1]] = {4'(i), v[0]};
        end
        cube_corners = nc;
        cube_edges   = ne;
    endfunction

    function automatic t_cube_word step_cube(cmse_pkg::t_opcode op, cmse_pkg::t_move mv,
                                             logic [cmse_pkg::CORNER_W-1:0] cw,
                                             logic [cmse_pkg::EDGE_W-1:0] ew);
        t_cube_word w;
        case (op)
            cmse_pkg::OP_MOVE:   turn_face(int'(mv));
            cmse_pkg::OP_SOLVE:  solve_cube();
            cmse_pkg::OP_INVERT: invert_cube();
            default: begin
                for (int i = 0; i < cmse_pkg::NUM_CORNERS; i++) begin
                    cube_corners[i] = cw[cmse_pkg::CODE_W*i +: cmse_pkg::CODE_W];
                end
                for (int i = 0; i < cmse_pkg::NUM_EDGES; i++) begin
                    cube_edges[i] = ew[cmse_pkg::CODE_W*i +: cmse_pkg::CODE_W];
                end
            end
        endcase
        for (int i = 0; i < cmse_pkg::NUM_CORNERS; i++) begin
            w.corners[cmse_pkg::CODE_W*i +: cmse_pkg::CODE_W] = cube_corners[i];
        end
        for (int i = 0; i < cmse_pkg::NUM_EDGES; i++) begin
            w.edges[cmse_pkg::CODE_W*i +: cmse_pkg::CODE_W] = cube_edges[i];
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Present one request, hold it until taken, then record its predicted state.
    // tvalid is left high; the next request or release_requests settles it.
    task automatic send_request(cmse_pkg::t_opcode op, cmse_pkg::t_move mv,
                                logic [cmse_pkg::CORNER_W-1:0] cw,
                                logic [cmse_pkg::EDGE_W-1:0] ew);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cmse_pkg::IN_TDATA_W'({ew, cw, mv, op});
        do @(posedge i_clk); while (!s_axis_tready);
        expected_states.push_back(step_cube(op, mv, cw, ew));
        requests_sent++;
        op_count[op]++;
    endtask

    task automatic release_requests();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Stop sending and hold until every predicted result has been seen.
    task automatic drain_results();
        release_requests();
        while (expected_states.size() != 0) @(posedge i_clk);
    endtask

    // Random state of permuted pieces: orientations mostly 0..2, sometimes 3.
    task automatic make_scramble(output logic [cmse_pkg::CORNER_W-1:0] cw,
                                 output logic [cmse_pkg::EDGE_W-1:0] ew);
        int perm_c [cmse_pkg::NUM_CORNERS];
        int perm_e [cmse_pkg::NUM_EDGES];
        int j;
        int tmp;
        int ori;
        for (int i = 0; i < cmse_pkg::NUM_CORNERS; i++) perm_c[i] = i;
        for (int i = 0; i < cmse_pkg::NUM_EDGES; i++) perm_e[i] = i;
        for (int i = cmse_pkg::NUM_CORNERS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm_c[i]; perm_c[i] = perm_c[j]; perm_c[j] = tmp;
        end
        for (int i = cmse_pkg::NUM_EDGES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm_e[i]; perm_e[i] = perm_e[j]; perm_e[j] = tmp;
        end
        for (int i = 0; i < cmse_pkg::NUM_CORNERS; i++) begin
            ori = ($urandom_range(0, 15) == 0) ? 3 : $urandom_range(0, 2);
            cw[cmse_pkg::CODE_W*i +: cmse_pkg::CODE_W] = {2'(ori), 3'(perm_c[i])};
        end
        for (int i = 0; i < cmse_pkg::NUM_EDGES; i++) begin
            ew[cmse_pkg::CODE_W*i +: cmse_pkg::CODE_W] =
                {4'(perm_e[i]), 1'($urandom_range(0, 1))};
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] %s: got %h want %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_cube_word exp_state;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_states.size() == 0) begin
                report_mismatch("result with no request pending",
                                64'(m_axis_tdata[cmse_pkg::CORNER_W-1:0]), 64'd0);
            end else begin
                exp_state = expected_states.pop_front();
                if (m_axis_tdata[cmse_pkg::CORNER_W-1:0] !== exp_state.corners) begin
                    report_mismatch("corner_word",
                                    64'(m_axis_tdata[cmse_pkg::CORNER_W-1:0]),
                                    64'(exp_state.corners));
                end
                if (m_axis_tdata[cmse_pkg::CORNER_W +: cmse_pkg::EDGE_W] !== exp_state.edges)
                begin
                    report_mismatch("edge_word",
                                    64'(m_axis_tdata[cmse_pkg::CORNER_W +: cmse_pkg::EDGE_W]),
                                    64'(exp_state.edges));
                end
                results_checked++;
            end
        end
    end

    // End the run if neither channel moves for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("cube_move_state_engine_top: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every face and twist in turn from solved, then indexes past the last move.
    task automatic test_face_turns();
        for (int m = 0; m < cmse_pkg::NUM_MOVES; m++) begin
            send_request(cmse_pkg::OP_MOVE, cmse_pkg::t_move'(m), '0, '0);
        end
        send_request(cmse_pkg::OP_MOVE, cmse_pkg::t_move'(cmse_pkg::NUM_MOVES), '1, '1);
        send_request(cmse_pkg::OP_MOVE, '1, '0, '0);
    endtask

    // Unchecked loads: orientation 3 twisted and carried, colliding inverts.
    task automatic test_odd_states();
        send_request(cmse_pkg::OP_LOAD, '0, '1, '1);
        send_request(cmse_pkg::OP_MOVE, cmse_pkg::t_move'(3), '0, '0);
        send_request(cmse_pkg::OP_MOVE, cmse_pkg::t_move'(0), '0, '0);
        send_request(cmse_pkg::OP_INVERT, '1, '0, '0);
        send_request(cmse_pkg::OP_LOAD, '1, '0, '0);
        send_request(cmse_pkg::OP_INVERT, '0, '1, '1);
        send_request(cmse_pkg::OP_SOLVE, '0, '1, '1);
        send_request(cmse_pkg::OP_INVERT, '0, '0, '0);
    endtask

    // Mostly scramble sequences of legal moves, with solves, inverts, scrambled and
    // noisy loads and out-of-range moves mixed in; hold off now and then.
    task automatic test_random_sequences(int count);
        int                            pick;
        logic [cmse_pkg::CORNER_W-1:0] cw;
        logic [cmse_pkg::EDGE_W-1:0]   ew;
        for (int n = 0; n < count; n++) begin
            if (n % 250 == 125) drain_results();
            pick = $urandom_range(0, 99);
            cw   = cmse_pkg::CORNER_W'({$urandom, $urandom});
            ew   = cmse_pkg::EDGE_W'({$urandom, $urandom});
            if (pick < 76) begin
                send_request(cmse_pkg::OP_MOVE,
                             cmse_pkg::t_move'($urandom_range(0, cmse_pkg::NUM_MOVES - 1)),
                             cw, ew);
            end else if (pick < 80) begin
                send_request(cmse_pkg::OP_MOVE,
                             cmse_pkg::t_move'($urandom_range(cmse_pkg::NUM_MOVES, 31)),
                             cw, ew);
            end else if (pick < 86) begin
                send_request(cmse_pkg::OP_INVERT, cmse_pkg::t_move'($urandom_range(0, 31)),
                             cw, ew);
            end else if (pick < 90) begin
                send_request(cmse_pkg::OP_SOLVE, cmse_pkg::t_move'($urandom_range(0, 31)),
                             cw, ew);
            end else if (pick < 97) begin
                make_scramble(cw, ew);
                send_request(cmse_pkg::OP_LOAD, cmse_pkg::t_move'($urandom_range(0, 31)),
                             cw, ew);
            end else begin
                send_request(cmse_pkg::OP_LOAD, cmse_pkg::t_move'($urandom_range(0, 31)),
                             cw, ew);
            end
        end
    endtask

    initial begin
        solve_cube();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver stalls heavily.
        tx_idle_pct = 24;
        rx_idle_pct = 62;
        test_face_turns();
        test_odd_states();
        test_random_sequences(600);
        drain_results();

        // Swap: sender idles heavily, receiver stalls lightly.
        tx_idle_pct = 62;
        rx_idle_pct = 24;
        test_random_sequences(600);

        // Back to back on both sides.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_sequences(550);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests: %0d moves, %0d solves, %0d inverts, %0d loads",
                 requests_sent, op_count[cmse_pkg::OP_MOVE], op_count[cmse_pkg::OP_SOLVE],
                 op_count[cmse_pkg::OP_INVERT], op_count[cmse_pkg::OP_LOAD]);
        $display("checked %0d results under three stall mixes, %0d mismatches",
                 results_checked, mismatches);
        if (mismatches == 0 && expected_states.size() == 0) begin
            $display("cube_move_state_engine_top: match");
        end else begin
            $display("cube_move_state_engine_top: mismatch");
        end
        $finish;
    end

endmodule
